/* rtl/chd_pkg.sv */
package chd_pkg;

	localparam int SizeBitsDefault = 32;

	localparam logic [7:0] ByteLf    = 8'h0A;
	localparam logic [7:0] ByteTab   = 8'h09;
	localparam logic [7:0] ByteCr    = 8'h0D;
	localparam logic [7:0] ByteSpace = 8'h20;

	typedef enum logic [2:0] {
		PH_WS      = 3'd0,
		PH_DIGITS  = 3'd1,
		PH_LINE    = 3'd2,
		PH_DATA    = 3'd3,
		PH_TRAILER = 3'd4,
		PH_DONE    = 3'd5
	} phase_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] value;
	} hex_digit_t;

	function automatic hex_digit_t hex_decode(input logic [7:0] b);
		hex_digit_t d;
		d.ok    = 1'b0;
		d.value = 4'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			d.ok    = 1'b1;
			d.value = 4'(b - 8'h30);
		end else if (b >= 8'h41 && b <= 8'h46) begin
			d.ok    = 1'b1;
			d.value = 4'(b - 8'h37);
		end else if (b >= 8'h61 && b <= 8'h66) begin
			d.ok    = 1'b1;
			d.value = 4'(b - 8'h57);
		end
		return d;
	endfunction

	function automatic logic is_space(input logic [7:0] b);
		return (b == ByteSpace) || (b >= ByteTab && b <= ByteCr);
	endfunction

endpackage

/* rtl/http_chunked_body_decoder.sv */
// Chunked body decoder: strips the size lines and framing of a chunked HTTP body.
// Input channel in_valid/in_ready/in_byte takes one raw body byte per word.
// Output channel out_valid/out_ready carries out_byte, body_end and size_error.
// Each accepted byte is decoded in the cycle it is accepted; a payload byte or an
// end marker appears in the output register on the next cycle.
// Throughput is one byte per cycle while out_ready is high; the single output
// register lets a new byte be accepted in the same cycle the held word is taken.
// If the receiver stalls with a word held, in_ready drops until that word leaves.
// Size-line bytes and the two framing bytes after each chunk give no output word.
// The end marker has out_byte zero and body_end set; size_error is also set when
// the chunk size does not fit in SIZE_BITS bits. After the end marker, all
// further bytes are accepted and dropped until reset.
// Reset (arst_n low, asynchronous) clears the output valid flag and returns the
// decoder to the start of a size line.
module http_chunked_body_decoder #(
	parameter int SIZE_BITS = chd_pkg::SizeBitsDefault
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       body_end,
	output logic       size_error
);
	import chd_pkg::*;

	phase_t               phase_q, phase_d;
	logic [SIZE_BITS-1:0] rem_q, rem_d;
	logic                 trailer_q, trailer_d;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       body_end_q;
	logic       size_error_q;

	logic       accept;
	logic       emit;
	logic [7:0] emit_byte;
	logic       emit_end;
	logic       emit_err;
	hex_digit_t hex;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign hex      = hex_decode(in_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_WS;
			rem_q     <= '0;
			trailer_q <= 1'b0;
		end else begin
			phase_q   <= phase_d;
			rem_q     <= rem_d;
			trailer_q <= trailer_d;
		end
	end

	always_comb begin
		phase_d   = phase_q;
		rem_d     = rem_q;
		trailer_d = trailer_q;
		emit      = 1'b0;
		emit_byte = 8'd0;
		emit_end  = 1'b0;
		emit_err  = 1'b0;
		if (accept) begin
			case (phase_q)
				PH_WS: begin
					if (!is_space(in_byte)) begin
						if (!hex.ok) begin
							phase_d  = PH_DONE;
							emit     = 1'b1;
							emit_end = 1'b1;
						end else begin
							rem_d   = {{(SIZE_BITS-4){1'b0}}, hex.value};
							phase_d = PH_DIGITS;
						end
					end
				end
				PH_DIGITS: begin
					if (hex.ok) begin
						if (rem_q[SIZE_BITS-1 -: 4] != 4'd0) begin
							phase_d  = PH_DONE;
							rem_d    = '0;
							emit     = 1'b1;
							emit_end = 1'b1;
							emit_err = 1'b1;
						end else begin
							rem_d = {rem_q[SIZE_BITS-5:0], hex.value};
						end
					end else if (rem_q == '0) begin
						phase_d  = PH_DONE;
						emit     = 1'b1;
						emit_end = 1'b1;
					end else begin
						phase_d = (in_byte == ByteLf) ? PH_DATA : PH_LINE;
					end
				end
				PH_LINE: begin
					if (in_byte == ByteLf) begin
						phase_d = PH_DATA;
					end
				end
				PH_DATA: begin
					rem_d     = rem_q - {{(SIZE_BITS-1){1'b0}}, 1'b1};
					emit      = 1'b1;
					emit_byte = in_byte;
					if (rem_q == {{(SIZE_BITS-1){1'b0}}, 1'b1}) begin
						phase_d   = PH_TRAILER;
						trailer_d = 1'b0;
					end
				end
				PH_TRAILER: begin
					if (trailer_q) begin
						trailer_d = 1'b0;
						phase_d   = PH_WS;
					end else begin
						trailer_d = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= accept && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			out_byte_q   <= emit_byte;
			body_end_q   <= emit_end;
			size_error_q <= emit_err;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign body_end   = body_end_q;
	assign size_error = size_error_q;

	a_err_ends_body: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && size_error |-> body_end)
		else $error("size error word without body end");

	a_end_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && body_end |-> out_byte == 8'd0)
		else $error("end word carries a nonzero byte");

	a_nothing_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && body_end |=> !out_valid)
		else $error("word emitted after end of body");

	a_done_silent: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DONE && accept |=> !(out_valid && !body_end))
		else $error("payload emitted after end of body");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
	import chd_pkg::*;

	localparam int SIZE_BITS = SizeBitsDefault;
	localparam int BODY_BYTES = 750;
	localparam logic [7:0] ByteSemi = 8'h3B;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       err;
	} body_word_t;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] in_byte = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_byte;
	logic       body_end;
	logic       size_error;

	logic [7:0] body_q[$];
	body_word_t word_q[$];

	phase_t                 ph = PH_WS;
	logic [SIZE_BITS-1:0]   chunk_left = '0;
	logic [1:0]             framing_seen = 2'd0;

	int    errors = 0;
	int    words_seen = 0;
	int    bytes_taken = 0;
	int    chunks_sent = 0;
	bit    hold_rx = 1'b0;
	bit    in_taken = 1'b0;
	string end_kind = "nothing";

	http_chunked_body_decoder #(
		.SIZE_BITS(SIZE_BITS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.body_end  (body_end),
		.size_error(size_error)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic hex_nibble(input logic [7:0] b, output logic [3:0] v);
		v = 4'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			v = b[3:0];
			return 1'b1;
		end
		if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
			v = b[3:0] + 4'd9;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic int idle_pct(input bit sender);
		if (bytes_taken < BODY_BYTES / 3)
			return sender ? 10 : 65;
		if (bytes_taken < 2 * BODY_BYTES / 3)
			return sender ? 65 : 10;
		return 0;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		if (v < 4'd10)
			return 8'h30 + 8'(v);
		return (($urandom_range(0, 1) == 0) ? 8'h61 : 8'h41) + 8'(v) - 8'd10;
	endfunction

	function automatic logic [7:0] space_char();
		int r;
		r = $urandom_range(0, 5);
		return (r == 5) ? ByteSpace : ByteTab + 8'(r);
	endfunction

	function automatic logic [7:0] non_lf_char();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == ByteLf);
		return b;
	endfunction

	task automatic put_size(input int unsigned n, input int zeros);
		int  s;
		bit  started;
		started = 1'b0;
		repeat (zeros) body_q.push_back(hex_char(4'd0));
		for (s = 28; s >= 0; s -= 4) begin
			if (((n >> s) & 4'hF) != 0 || started || s == 0) begin
				started = 1'b1;
				body_q.push_back(hex_char(4'((n >> s) & 4'hF)));
			end
		end
	endtask

	task automatic add_chunk();
		int unsigned len;
		int          r;
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) body_q.push_back(space_char());
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 300) : $urandom_range(1, 16);
		put_size(len, ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0);
		case ($urandom_range(0, 3))
			0: body_q.push_back(ByteLf);
			1: begin
				body_q.push_back(ByteCr);
				body_q.push_back(ByteLf);
			end
			default: begin
				r = $urandom_range(0, 3);
				body_q.push_back((r == 0) ? ByteSemi : (r == 1) ? ByteSpace :
					(r == 2) ? ByteTab : ByteCr);
				repeat ($urandom_range(0, 6)) body_q.push_back(non_lf_char());
				body_q.push_back(ByteLf);
			end
		endcase
		repeat (len) body_q.push_back(8'($urandom_range(0, 255)));
		if ($urandom_range(0, 4) != 0) begin
			body_q.push_back(ByteCr);
			body_q.push_back(ByteLf);
		end else begin
			body_q.push_back(8'($urandom_range(0, 255)));
			body_q.push_back(8'($urandom_range(0, 255)));
		end
		chunks_sent++;
	endtask

	task automatic add_ending();
		logic [7:0] b;
		logic [3:0] nib;
		if ($urandom_range(0, 1) == 0)
			body_q.push_back(space_char());
		case ($urandom_range(0, 2))
			0: begin
				end_kind = "a zero-size chunk";
				put_size(0, $urandom_range(0, 2));
				body_q.push_back(($urandom_range(0, 1) == 0) ? ByteCr : ByteSemi);
				body_q.push_back(ByteLf);
			end
			1: begin
				end_kind = "a size line without digits";
				do
					b = 8'($urandom_range(0, 255));
				while (hex_nibble(b, nib) || b == ByteSpace || (b >= ByteTab && b <= ByteCr));
				body_q.push_back(b);
			end
			default: begin
				end_kind = "an oversize chunk length";
				body_q.push_back(hex_char(4'($urandom_range(1, 15))));
				repeat (8) body_q.push_back(hex_char(4'($urandom_range(0, 15))));
			end
		endcase
		repeat (8) body_q.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic decode_byte(input logic [7:0] b);
		logic [3:0] nib;
		logic       is_hex;
		logic       is_ws;
		is_hex = hex_nibble(b, nib);
		is_ws = (b == ByteSpace) || (b >= ByteTab && b <= ByteCr);
		case (ph)
			PH_WS: begin
				if (!is_ws) begin
					if (!is_hex) begin
						ph = PH_DONE;
						word_q.push_back('{8'h00, 1'b1, 1'b0});
					end else begin
						chunk_left = SIZE_BITS'(nib);
						ph = PH_DIGITS;
					end
				end
			end
			PH_DIGITS: begin
				if (is_hex) begin
					if ((chunk_left >> (SIZE_BITS - 4)) != 0) begin
						ph = PH_DONE;
						chunk_left = '0;
						word_q.push_back('{8'h00, 1'b1, 1'b1});
					end else begin
						chunk_left = {chunk_left[SIZE_BITS-5:0], nib};
					end
				end else if (chunk_left == 0) begin
					ph = PH_DONE;
					word_q.push_back('{8'h00, 1'b1, 1'b0});
				end else begin
					ph = (b == ByteLf) ? PH_DATA : PH_LINE;
				end
			end
			PH_LINE: begin
				if (b == ByteLf)
					ph = PH_DATA;
			end
			PH_DATA: begin
				chunk_left = chunk_left - 1'b1;
				if (chunk_left == 0) begin
					ph = PH_TRAILER;
					framing_seen = 2'd0;
				end
				word_q.push_back('{b, 1'b0, 1'b0});
			end
			PH_TRAILER: begin
				framing_seen = framing_seen + 2'd1;
				if (framing_seen >= 2'd2) begin
					framing_seen = 2'd0;
					ph = PH_WS;
				end
			end
			default: ;
		endcase
	endtask

	task automatic check_word();
		body_word_t want;
		if (word_q.size() == 0) begin
			$error("unexpected output word: out_byte %02h body_end %0b size_error %0b",
				out_byte, body_end, size_error);
			errors++;
		end else begin
			want = word_q.pop_front();
			words_seen++;
			if (out_byte !== want.data) begin
				$error("out_byte: expected %02h, got %02h", want.data, out_byte);
				errors++;
			end
			if (body_end !== want.last) begin
				$error("body_end: expected %0b, got %0b", want.last, body_end);
				errors++;
			end
			if (size_error !== want.err) begin
				$error("size_error: expected %0b, got %0b", want.err, size_error);
				errors++;
			end
		end
	endtask

	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (body_q.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
				in_valid <= 1'b1;
				in_byte <= body_q.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n)
			out_ready <= !hold_rx && ($urandom_range(0, 99) >= idle_pct(1'b0));
	end

	always @(posedge clk) begin
		in_taken <= in_valid && in_ready;
		if (arst_n) begin
			if (out_valid && out_ready)
				check_word();
			if (in_valid && in_ready) begin
				bytes_taken++;
				decode_byte(in_byte);
			end
		end
	end

	// The receiver stops for a long stretch so the decoder backs up into its input.
	initial begin
		wait (bytes_taken >= 600);
		@(posedge clk);
		hold_rx = 1'b1;
		repeat (200) @(posedge clk);
		hold_rx = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("Timeout with %0d words still expected.", word_q.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		body_q = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h30, 8'h33, ByteSemi, 8'h65,
			8'h0A, 8'h00, 8'hFF, 8'h0A, 8'h0D, 8'h0A};
		chunks_sent = 1;
		while (body_q.size() < BODY_BYTES)
			add_chunk();
		add_ending();
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait (body_q.size() == 0 && !in_valid);
		wait (word_q.size() == 0);
		repeat (20) @(posedge clk);
		$display("Fed %0d body bytes in %0d chunks and checked %0d output words.",
			bytes_taken, chunks_sent, words_seen);
		$display("The body was closed by %s, followed by ignored bytes.", end_kind);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* files.f */
rtl/chd_pkg.sv
rtl/http_chunked_body_decoder.sv
tb/testbench.sv
